// ===== rtl/tto_pkg.sv =====
// Shared types, codes and glyph lookup for the tile text overlay block.
`default_nettype none
package tto_pkg;

   localparam int MAP_AW  = 10;
   localparam int TILE_W  = 16;
   localparam int GLYPH_W = 5;
   localparam int CSR_W   = 10;
   localparam int CSR_AW  = 2;

   typedef enum logic [1:0] {
      OP_MAP_WRITE = 2'd0,
      OP_MAP_READ  = 2'd1,
      OP_PUT_CHAR  = 2'd2,
      OP_RESTORE   = 2'd3
   } opcode_type;

   typedef enum logic [CSR_AW-1:0] {
      CSR_SCROLL_X  = 2'd0,
      CSR_SCROLL_Y  = 2'd1,
      CSR_FONT_BASE = 2'd2,
      CSR_PALETTE   = 2'd3
   } csr_index_type;

   localparam logic [9:0] FONT_BASE_RESET = 10'd234;
   localparam logic [3:0] PALETTE_RESET   = 4'd15;

   // Fold lower case to upper, then find the glyph slot; unknown is blank.
   function automatic logic [GLYPH_W-1:0] glyph_of(input logic [7:0] code);
      logic [7:0] c;
      logic [GLYPH_W-1:0] g;
      c = code;
      if (code >= 8'h61 && code <= 8'h7A) begin
         c = code - 8'h20;
      end
      unique case (c)
         8'h20:   g = 5'd0;
         8'h30:   g = 5'd1;
         8'h31:   g = 5'd2;
         8'h32:   g = 5'd3;
         8'h33:   g = 5'd4;
         8'h34:   g = 5'd5;
         8'h35:   g = 5'd6;
         8'h36:   g = 5'd7;
         8'h37:   g = 5'd8;
         8'h38:   g = 5'd9;
         8'h39:   g = 5'd10;
         8'h54:   g = 5'd11;
         8'h41:   g = 5'd12;
         8'h52:   g = 5'd13;
         8'h58:   g = 5'd14;
         8'h59:   g = 5'd15;
         8'h5A:   g = 5'd16;
         8'h46:   g = 5'd17;
         8'h50:   g = 5'd18;
         8'h2B:   g = 5'd19;
         8'h2D:   g = 5'd20;
         8'h3A:   g = 5'd21;
         default: g = 5'd0;
      endcase
      return g;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/tile_text_overlay_with_undo.sv =====
// Tile map with text overlay, undo log and host access.
// Result beats: map write and rejected put give their beat in the cycle after start; map read and
//   put give it from a second state, after the registered map read; restore of n entries gives n beats.
// Occupancy: write leaves the block idle; read and put hold it busy through a second state (one
//   map read port, then write-back); restore writes back one log entry per cycle from the log.
// Reset (synchronous, active high): empties the log, loads register defaults, idles.
// Map and log memories are not cleared; the receiver cannot stall result beats.
`default_nettype none
module tile_text_overlay_with_undo #(
   parameter int LOG_DEPTH       = 64,
   parameter int MAP_SIDE        = 32,
   parameter int VISIBLE_COLUMNS = 30,
   parameter int VISIBLE_ROWS    = 20
) (
   input  wire                        clock,
   input  wire                        reset,
   // request channel
   input  wire                        start,
   output logic                       busy,
   input  wire  [1:0]                 req_opcode,
   input  wire  [4:0]                 req_column,
   input  wire  [4:0]                 req_row,
   input  wire  [7:0]                 req_char_code,
   input  wire  [tto_pkg::MAP_AW-1:0] req_map_index,
   input  wire  [tto_pkg::TILE_W-1:0] req_map_data,
   // result channel
   output logic                       rsp_valid,
   output logic                       rsp_write_done,
   output logic [tto_pkg::MAP_AW-1:0] rsp_entry_index,
   output logic [tto_pkg::TILE_W-1:0] rsp_tile_word,
   output logic                       rsp_accepted,
   output logic [6:0]                 rsp_log_count,
   output logic                       rsp_last,
   // register write port
   input  wire                        csr_write_enable,
   input  wire  [tto_pkg::CSR_AW-1:0] csr_index,
   input  wire  [tto_pkg::CSR_W-1:0]  csr_write_data
);
   import tto_pkg::*;

   localparam int SIDE_W   = $clog2(MAP_SIDE);
   localparam int MAP_DEPTH = MAP_SIDE * MAP_SIDE;
   localparam int LOG_AW   = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
   localparam int CNT_W    = $clog2(LOG_DEPTH + 1);
   localparam int LOG_W    = MAP_AW + TILE_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ_WAIT,
      ST_PUT_WRITE,
      ST_RESTORE
   } state_type;

   // configuration registers
   logic [8:0] scroll_x_ff;
   logic [8:0] scroll_y_ff;
   logic [9:0] font_base_ff;
   logic [3:0] palette_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         scroll_x_ff  <= '0;
         scroll_y_ff  <= '0;
         font_base_ff <= FONT_BASE_RESET;
         palette_ff   <= PALETTE_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_SCROLL_X:  scroll_x_ff  <= csr_write_data[8:0];
            CSR_SCROLL_Y:  scroll_y_ff  <= csr_write_data[8:0];
            CSR_FONT_BASE: font_base_ff <= csr_write_data;
            CSR_PALETTE:   palette_ff   <= csr_write_data[3:0];
            default: ;
         endcase
      end
   end

   // control state
   state_type            state_ff;
   logic [CNT_W-1:0]     fill_ff;      // saved entries in the undo log
   logic [CNT_W-1:0]     walk_ff;      // restore position within the log
   logic [MAP_AW-1:0]    put_pos_ff;
   logic [TILE_W-1:0]    put_word_ff;

   // memories
   logic [TILE_W-1:0]    map_mem [MAP_DEPTH];
   logic [LOG_W-1:0]     log_mem [LOG_DEPTH];
   logic [TILE_W-1:0]    map_rd_data_ff;
   logic [LOG_W-1:0]     log_rd_data_ff;

   logic                 accept;
   opcode_type           opcode;
   logic                 put_reject;
   logic [SIDE_W-1:0]    map_col;
   logic [SIDE_W-1:0]    map_row;
   logic [MAP_AW-1:0]    put_pos;
   logic [11:0]          glyph_tile;
   logic [TILE_W-1:0]    put_word;

   logic                 map_rd_en;
   logic [MAP_AW-1:0]    map_rd_addr;
   logic                 map_wr_en;
   logic [MAP_AW-1:0]    map_wr_addr;
   logic [TILE_W-1:0]    map_wr_data;
   logic                 log_rd_en;
   logic [LOG_AW-1:0]    log_rd_addr;
   logic                 log_wr_en;

   logic [CNT_W-1:0]     walk_next;
   logic                 walk_last;
   logic [CNT_W-1:0]     remain;
   logic [CNT_W-1:0]     fill_plus;
   logic [MAP_AW-1:0]    log_pos;
   logic [TILE_W-1:0]    log_saved;
   logic [CNT_W+6:0]     cnt_ext_fill;
   logic [CNT_W+6:0]     cnt_ext_plus;
   logic [CNT_W+6:0]     cnt_ext_remain;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;
   assign opcode = opcode_type'(req_opcode);

   // screen position plus scroll in tiles, wrapping around the map
   assign map_col = req_column[SIDE_W-1:0] + scroll_x_ff[SIDE_W+2:3];
   assign map_row = req_row[SIDE_W-1:0] + scroll_y_ff[SIDE_W+2:3];
   assign put_pos = {map_row, map_col};

   assign glyph_tile = {2'b00, font_base_ff} + {7'd0, glyph_of(req_char_code)};
   assign put_word   = {palette_ff, glyph_tile};

   assign put_reject = ({1'b0, req_column} >= 6'(VISIBLE_COLUMNS))
                    || ({1'b0, req_row} >= 6'(VISIBLE_ROWS))
                    || (fill_ff >= CNT_W'(LOG_DEPTH));

   assign walk_next = walk_ff + 1'b1;
   assign walk_last = (walk_next == fill_ff);
   assign remain    = fill_ff - walk_next;
   assign fill_plus = fill_ff + 1'b1;
   assign log_pos   = log_rd_data_ff[LOG_W-1:TILE_W];
   assign log_saved = log_rd_data_ff[TILE_W-1:0];

   // log counts go out masked to seven bits
   assign cnt_ext_fill   = {7'd0, fill_ff};
   assign cnt_ext_plus   = {7'd0, fill_plus};
   assign cnt_ext_remain = {7'd0, remain};

   // memory port steering
   always_comb begin
      map_rd_en   = 1'b0;
      map_rd_addr = req_map_index;
      map_wr_en   = 1'b0;
      map_wr_addr = req_map_index;
      map_wr_data = req_map_data;
      log_rd_en   = 1'b0;
      log_rd_addr = walk_next[LOG_AW-1:0];
      log_wr_en   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (opcode)
                  OP_MAP_WRITE: map_wr_en = 1'b1;
                  OP_MAP_READ:  map_rd_en = 1'b1;
                  OP_PUT_CHAR: begin
                     map_rd_en   = !put_reject;
                     map_rd_addr = put_pos;
                  end
                  OP_RESTORE: begin
                     log_rd_en   = 1'b1;
                     log_rd_addr = '0;
                  end
                  default: ;
               endcase
            end
         end
         ST_PUT_WRITE: begin
            // tile read last cycle goes to the log, glyph word to the map
            map_wr_en   = 1'b1;
            map_wr_addr = put_pos_ff;
            map_wr_data = put_word_ff;
            log_wr_en   = 1'b1;
         end
         ST_RESTORE: begin
            // write back the entry read last cycle, fetch the next one
            map_wr_en   = 1'b1;
            map_wr_addr = log_pos;
            map_wr_data = log_saved;
            log_rd_en   = !walk_last;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (map_wr_en) begin
         map_mem[map_wr_addr] <= map_wr_data;
      end
      if (map_rd_en) begin
         map_rd_data_ff <= map_mem[map_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (log_wr_en) begin
         log_mem[fill_ff[LOG_AW-1:0]] <= {put_pos_ff, map_rd_data_ff};
      end
      if (log_rd_en) begin
         log_rd_data_ff <= log_mem[log_rd_addr];
      end
   end

   // sequencer and registered result beat
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         fill_ff   <= '0;
         walk_ff   <= '0;
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  unique case (opcode)
                     OP_MAP_WRITE: begin
                        rsp_valid       <= 1'b1;
                        rsp_write_done  <= 1'b1;
                        rsp_entry_index <= req_map_index;
                        rsp_tile_word   <= req_map_data;
                        rsp_accepted    <= 1'b1;
                        rsp_log_count   <= cnt_ext_fill[6:0];
                        rsp_last        <= 1'b1;
                     end
                     OP_MAP_READ: begin
                        rsp_entry_index <= req_map_index;
                        state_ff        <= ST_READ_WAIT;
                     end
                     OP_PUT_CHAR: begin
                        if (put_reject) begin
                           rsp_valid       <= 1'b1;
                           rsp_write_done  <= 1'b0;
                           rsp_entry_index <= '0;
                           rsp_tile_word   <= '0;
                           rsp_accepted    <= 1'b0;
                           rsp_log_count   <= cnt_ext_fill[6:0];
                           rsp_last        <= 1'b1;
                        end else begin
                           put_pos_ff  <= put_pos;
                           put_word_ff <= put_word;
                           state_ff    <= ST_PUT_WRITE;
                        end
                     end
                     OP_RESTORE: begin
                        if (fill_ff == '0) begin
                           // empty log: a single blank beat
                           rsp_valid       <= 1'b1;
                           rsp_write_done  <= 1'b0;
                           rsp_entry_index <= '0;
                           rsp_tile_word   <= '0;
                           rsp_accepted    <= 1'b1;
                           rsp_log_count   <= '0;
                           rsp_last        <= 1'b1;
                        end else begin
                           walk_ff  <= '0;
                           state_ff <= ST_RESTORE;
                        end
                     end
                     default: ;
                  endcase
               end
            end
            ST_READ_WAIT: begin
               rsp_valid      <= 1'b1;
               rsp_write_done <= 1'b0;
               rsp_tile_word  <= map_rd_data_ff;
               rsp_accepted   <= 1'b1;
               rsp_log_count  <= cnt_ext_fill[6:0];
               rsp_last       <= 1'b1;
               state_ff       <= ST_IDLE;
            end
            ST_PUT_WRITE: begin
               rsp_valid       <= 1'b1;
               rsp_write_done  <= 1'b1;
               rsp_entry_index <= put_pos_ff;
               rsp_tile_word   <= put_word_ff;
               rsp_accepted    <= 1'b1;
               rsp_log_count   <= cnt_ext_plus[6:0];
               rsp_last        <= 1'b1;
               fill_ff         <= fill_plus;
               state_ff        <= ST_IDLE;
            end
            ST_RESTORE: begin
               rsp_valid       <= 1'b1;
               rsp_write_done  <= 1'b1;
               rsp_entry_index <= log_pos;
               rsp_tile_word   <= log_saved;
               rsp_accepted    <= 1'b1;
               rsp_log_count   <= cnt_ext_remain[6:0];
               rsp_last        <= walk_last;
               walk_ff         <= walk_next;
               if (walk_last) begin
                  fill_ff  <= '0;
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule
`default_nettype wire

// ===== test/overlay_scoreboard_pkg.sv =====
// Scoreboard for the tile text overlay: map image, undo log image and expected beats.
`timescale 1ns / 1ps
package overlay_scoreboard_pkg;
   import tto_pkg::*;

   localparam int MAP_ENTRIES   = 1024;
   localparam int UNDO_DEPTH    = 64;
   localparam int SHOWN_COLUMNS = 30;
   localparam int SHOWN_ROWS    = 20;

   typedef struct packed {
      opcode_type  opcode;
      logic [4:0]  column;
      logic [4:0]  row;
      logic [7:0]  char_code;
      logic [9:0]  map_index;
      logic [15:0] map_data;
   } overlay_request;

   // field order matches the rsp_ port order, so a concatenation fills it
   typedef struct packed {
      logic        write_done;
      logic [9:0]  entry_index;
      logic [15:0] tile_word;
      logic        accepted;
      logic [6:0]  log_count;
      logic        last;
   } overlay_beat;

   class overlay_scoreboard;
      logic [15:0] map_image [MAP_ENTRIES];
      bit          map_known [MAP_ENTRIES];
      logic [9:0]  undo_entry [UNDO_DEPTH];
      logic [15:0] undo_tile [UNDO_DEPTH];
      int          undo_fill;
      logic [8:0]  scroll_x;
      logic [8:0]  scroll_y;
      logic [9:0]  font_base;
      logic [3:0]  palette;
      overlay_beat expected_beats [$];
      int          errors;
      int          beats_seen;

      function new();
         foreach (map_known[i]) map_known[i] = 1'b0;
         undo_fill  = 0;
         scroll_x   = '0;
         scroll_y   = '0;
         font_base  = FONT_BASE_RESET;
         palette    = PALETTE_RESET;
         errors     = 0;
         beats_seen = 0;
      endfunction

      function void report(string msg);
         $display("[%0t] mismatch: %s", $time, msg);
         errors++;
      endfunction

      function void set_register(csr_index_type idx, logic [9:0] value);
         case (idx)
            CSR_SCROLL_X:  scroll_x  = value[8:0];
            CSR_SCROLL_Y:  scroll_y  = value[8:0];
            CSR_FONT_BASE: font_base = value;
            CSR_PALETTE:   palette   = value[3:0];
            default: ;
         endcase
      endfunction

      // scroll is in pixels; tiles are 8 wide and the map wraps at 32
      function logic [9:0] target_entry(logic [4:0] column, logic [4:0] row);
         logic [4:0] map_row;
         logic [4:0] map_col;
         map_row = row + scroll_y[7:3];
         map_col = column + scroll_x[7:3];
         return {map_row, map_col};
      endfunction

      function bit put_fits(logic [4:0] column, logic [4:0] row);
         return column < SHOWN_COLUMNS && row < SHOWN_ROWS && undo_fill < UNDO_DEPTH;
      endfunction

      function logic [15:0] glyph_tile(logic [7:0] code);
         string      alphabet;
         logic [7:0] folded;
         logic [11:0] slot;
         alphabet = " 0123456789TARXYZFP+-:";
         folded = (code >= 8'h61 && code <= 8'h7A) ? code - 8'h20 : code;
         slot = '0;  // unknown characters draw the blank
         for (int g = 0; g < alphabet.len(); g++)
            if (alphabet[g] == folded) slot = 12'(g);
         return {palette, 12'(font_base) + slot};
      endfunction

      function void note_request(overlay_request req);
         overlay_beat beat;
         logic [9:0]  pos;
         beat = '0;
         beat.last = 1'b1;
         beat.log_count = 7'(undo_fill);
         case (req.opcode)
            OP_MAP_WRITE: begin
               map_image[req.map_index] = req.map_data;
               map_known[req.map_index] = 1'b1;
               beat.write_done  = 1'b1;
               beat.entry_index = req.map_index;
               beat.tile_word   = req.map_data;
               beat.accepted    = 1'b1;
               expected_beats.push_back(beat);
            end
            OP_MAP_READ: begin
               beat.entry_index = req.map_index;
               beat.tile_word   = map_image[req.map_index];
               beat.accepted    = 1'b1;
               expected_beats.push_back(beat);
            end
            OP_PUT_CHAR: begin
               if (put_fits(req.column, req.row)) begin
                  pos = target_entry(req.column, req.row);
                  undo_entry[undo_fill] = pos;
                  undo_tile[undo_fill]  = map_image[pos];
                  undo_fill++;
                  map_image[pos]   = glyph_tile(req.char_code);
                  beat.write_done  = 1'b1;
                  beat.entry_index = pos;
                  beat.tile_word   = map_image[pos];
                  beat.accepted    = 1'b1;
                  beat.log_count   = 7'(undo_fill);
               end
               expected_beats.push_back(beat);
            end
            OP_RESTORE: begin
               beat.accepted = 1'b1;
               if (undo_fill == 0) begin
                  expected_beats.push_back(beat);
               end else begin
                  for (int k = 0; k < undo_fill; k++) begin
                     map_image[undo_entry[k]] = undo_tile[k];
                     beat.write_done  = 1'b1;
                     beat.entry_index = undo_entry[k];
                     beat.tile_word   = undo_tile[k];
                     beat.log_count   = 7'(undo_fill - k - 1);
                     beat.last        = (k == undo_fill - 1);
                     expected_beats.push_back(beat);
                  end
                  undo_fill = 0;
               end
            end
            default: ;
         endcase
      endfunction

      function void compare_field(string name, logic [15:0] got, logic [15:0] want);
         if (got !== want)
            report($sformatf("beat %0d %s: got %0h, expected %0h", beats_seen, name, got, want));
      endfunction

      function void check_beat(overlay_beat got);
         overlay_beat want;
         beats_seen++;
         if (expected_beats.size() == 0) begin
            report($sformatf("beat %0d arrived with nothing expected (entry %0h word %0h)",
                             beats_seen, got.entry_index, got.tile_word));
            return;
         end
         want = expected_beats.pop_front();
         compare_field("write_done", 16'(got.write_done), 16'(want.write_done));
         compare_field("entry_index", 16'(got.entry_index), 16'(want.entry_index));
         compare_field("tile_word", got.tile_word, want.tile_word);
         compare_field("accepted", 16'(got.accepted), 16'(want.accepted));
         compare_field("log_count", 16'(got.log_count), 16'(want.log_count));
         compare_field("last", 16'(got.last), 16'(want.last));
      endfunction

      function void close_out();
         if (expected_beats.size() != 0)
            report($sformatf("%0d expected beats never arrived", expected_beats.size()));
      endfunction
   endclass

endpackage

// ===== test/tb_tile_text_overlay_with_undo.sv =====
// Testbench top for the tile text overlay with undo: stimulus, result monitor and run control.
`timescale 1ns / 1ps
module tb_tile_text_overlay_with_undo;
   import tto_pkg::*;
   import overlay_scoreboard_pkg::*;

   localparam int CYCLE_LIMIT = 400000;  // slowest legal run stays well under this limit
   localparam int ITEM_TARGET = 410;     // requests in all, host writes before puts included

   logic        clock            = 1'b0;
   logic        reset            = 1'b1;
   logic        start            = 1'b0;
   logic [1:0]  req_opcode       = '0;
   logic [4:0]  req_column       = '0;
   logic [4:0]  req_row          = '0;
   logic [7:0]  req_char_code    = '0;
   logic [9:0]  req_map_index    = '0;
   logic [15:0] req_map_data     = '0;
   logic        csr_write_enable = 1'b0;
   logic [1:0]  csr_index        = '0;
   logic [9:0]  csr_write_data   = '0;

   logic        busy;
   logic        rsp_valid;
   logic        rsp_write_done;
   logic [9:0]  rsp_entry_index;
   logic [15:0] rsp_tile_word;
   logic        rsp_accepted;
   logic [6:0]  rsp_log_count;
   logic        rsp_last;

   overlay_scoreboard sb;
   int cycle_count   = 0;
   int items_sent    = 0;
   int config_phases = 0;
   bit back_to_back  = 1'b0;  // when set the sender inserts no gaps between requests

   tile_text_overlay_with_undo DUT (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_opcode       (req_opcode),
      .req_column       (req_column),
      .req_row          (req_row),
      .req_char_code    (req_char_code),
      .req_map_index    (req_map_index),
      .req_map_data     (req_map_data),
      .rsp_valid        (rsp_valid),
      .rsp_write_done   (rsp_write_done),
      .rsp_entry_index  (rsp_entry_index),
      .rsp_tile_word    (rsp_tile_word),
      .rsp_accepted     (rsp_accepted),
      .rsp_log_count    (rsp_log_count),
      .rsp_last         (rsp_last),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   // Watchdog: a hang or a lost beat ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Result monitor. Outputs are read at the rising edge, i.e. the values of the
   // cycle that the edge ends; the receiver has no way to stall, so every beat counts.
   always @(posedge clock) begin
      if (!reset && rsp_valid !== 1'b0)
         sb.check_beat({rsp_write_done, rsp_entry_index, rsp_tile_word,
                        rsp_accepted, rsp_log_count, rsp_last});
   end

   // Mostly short gaps, now and then a long one; none at all in back-to-back phases.
   function automatic int pick_gap();
      int roll;
      if (back_to_back) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 40) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Fields that the operation ignores still carry random values.
   function automatic overlay_request noise_item(opcode_type op);
      overlay_request item;
      item.opcode    = op;
      item.column    = 5'($urandom);
      item.row       = 5'($urandom);
      item.char_code = 8'($urandom);
      item.map_index = 10'($urandom);
      item.map_data  = 16'($urandom);
      return item;
   endfunction

   // Half glyph characters (either case), half arbitrary bytes.
   function automatic logic [7:0] random_char();
      string pool;
      pool = " 0123456789TARXYZFP+-:tarxyzfp";
      if ($urandom_range(0, 1) == 1) return pool[$urandom_range(0, pool.len() - 1)];
      return 8'($urandom);
   endfunction

   // Map entries are undefined until written: reads only go to entries the host wrote.
   function automatic logic [9:0] pick_known_entry();
      logic [9:0] idx;
      idx = 10'($urandom);
      while (!sb.map_known[idx]) idx = idx + 1'b1;
      return idx;
   endfunction

   // Called at a falling edge, returns at the falling edge after the accepting rise.
   // busy only moves on rising edges, so its value here is the one the next rise sees.
   task automatic send(overlay_request item);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_opcode    <= item.opcode;
      req_column    <= item.column;
      req_row       <= item.row;
      req_char_code <= item.char_code;
      req_map_index <= item.map_index;
      req_map_data  <= item.map_data;
      start         <= 1'b1;
      while (busy) @(negedge clock);
      @(posedge clock);
      sb.note_request(item);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic map_write(logic [9:0] idx, logic [15:0] data);
      overlay_request item;
      item = noise_item(OP_MAP_WRITE);
      item.map_index = idx;
      item.map_data  = data;
      send(item);
   endtask

   task automatic map_read(logic [9:0] idx);
      overlay_request item;
      item = noise_item(OP_MAP_READ);
      item.map_index = idx;
      send(item);
   endtask

   // A put saves the old tile, so its target must hold a defined word first.
   task automatic put_char(logic [4:0] column, logic [4:0] row, logic [7:0] code);
      overlay_request item;
      logic [9:0]     target;
      target = sb.target_entry(column, row);
      if (sb.put_fits(column, row) && !sb.map_known[target])
         map_write(target, 16'($urandom));
      item = noise_item(OP_PUT_CHAR);
      item.column    = column;
      item.row       = row;
      item.char_code = code;
      send(item);
   endtask

   task automatic restore_all();
      send(noise_item(OP_RESTORE));
   endtask

   // Hold off until every expected beat is in and the block is idle.
   task automatic quiesce();
      start <= 1'b0;
      while (sb.expected_beats.size() != 0 || busy) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_register(csr_index_type idx, logic [9:0] value);
      csr_index        <= idx;
      csr_write_data   <= value;
      csr_write_enable <= 1'b1;
      sb.set_register(idx, value);
      @(negedge clock);
   endtask

   task automatic program_registers(logic [9:0] sx, logic [9:0] sy, logic [9:0] base,
                                    logic [9:0] pal);
      quiesce();
      write_register(CSR_SCROLL_X, sx);
      write_register(CSR_SCROLL_Y, sy);
      write_register(CSR_FONT_BASE, base);
      write_register(CSR_PALETTE, pal);
      csr_write_enable <= 1'b0;
      config_phases++;
   endtask

   task automatic random_burst(int count);
      int         roll;
      logic [4:0] col;
      logic [4:0] row;
      logic [9:0] target;
      repeat (count) begin
         roll = $urandom_range(0, 99);
         col  = 5'($urandom_range(0, 29));
         row  = 5'($urandom_range(0, 19));
         if (roll < 38) begin
            put_char(col, row, random_char());
         end else if (roll < 50) begin
            // anywhere on the 32x32 grid: many of these are range rejects
            put_char(5'($urandom), 5'($urandom), random_char());
         end else if (roll < 64) begin
            map_write(10'($urandom), 16'($urandom));
         end else if (roll < 78) begin
            map_read(pick_known_entry());
         end else if (roll < 86) begin
            restore_all();
         end else if (roll < 88) begin
            quiesce();
         end else begin
            // draw, then read the same entry straight back
            target = sb.target_entry(col, row);
            put_char(col, row, random_char());
            if (sb.map_known[target]) map_read(target);
         end
      end
   endtask

   initial begin
      sb = new();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part, on the register values from reset.
      restore_all();                  // empty log: one bare beat
      map_write(10'd0, 16'h0000);
      map_write(10'd1023, 16'hFFFF);
      map_read(10'd0);
      map_read(10'd1023);
      put_char(5'd0, 5'd0, 8'h20);    // blank, top left corner
      put_char(5'd29, 5'd19, 8'h61);  // lower case folds, bottom right visible cell
      put_char(5'd7, 5'd3, 8'h7A);
      put_char(5'd8, 5'd3, 8'h3A);
      put_char(5'd9, 5'd3, 8'h00);    // unknown codes draw the blank
      put_char(5'd10, 5'd3, 8'hFF);
      put_char(5'd11, 5'd3, 8'h39);
      put_char(5'd12, 5'd3, 8'h70);
      put_char(5'd30, 5'd0, 8'h54);   // column and row range rejects
      put_char(5'd31, 5'd19, 8'h2B);
      put_char(5'd0, 5'd20, 8'h2D);
      put_char(5'd31, 5'd31, 8'h30);
      map_read(10'd637);
      restore_all();
      map_read(10'd637);

      // Register extremes: full scroll wraps the map, top font base, palette zero.
      // Fill the log to the brim, bounce one put off the full log, then unwind all of it.
      program_registers(10'h3FF, 10'h3FF, 10'd1002, 10'd0);
      back_to_back = 1'b1;
      random_burst(30);
      while (sb.undo_fill < UNDO_DEPTH)
         put_char(5'($urandom_range(0, 29)), 5'($urandom_range(0, 19)), random_char());
      put_char(5'($urandom_range(0, 29)), 5'($urandom_range(0, 19)), random_char());
      restore_all();
      back_to_back = 1'b0;

      program_registers(10'd0, 10'd0, 10'd0, 10'd15);
      random_burst(50);

      // Random settings; every third phase runs without sender gaps.
      for (int phase = 0; items_sent < ITEM_TARGET; phase++) begin
         program_registers(10'($urandom), 10'($urandom), 10'($urandom_range(0, 1002)),
                           10'($urandom));
         back_to_back = (phase % 3 == 1);
         random_burst(20);
      end

      quiesce();
      repeat (8) @(negedge clock);
      sb.close_out();
      $display("Summary: %0d requests and %0d result beats over %0d register settings.",
               items_sent, sb.beats_seen, config_phases);
      $display("Summary: range and full-log rejects, a 64-entry unwind, %0d mismatches.",
               sb.errors);
      if (sb.errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
